// ----- sv/chtq_pkg.sv -----
// shared types and constants of the counting hash table
`timescale 1ns / 1ps

package chtq_pkg;

   localparam int KEY_W     = 32;
   localparam int COUNT_W   = 16;
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 2;
   localparam int SLOT_W    = 2;

   // key reduction runs this many key bits per cycle
   localparam int MOD_BITS  = 8;
   localparam int MOD_STEPS = KEY_W / MOD_BITS;
   localparam int MOD_CNT_W = $clog2(MOD_STEPS);

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [SLOT_W-1:0]   slot_state_type;

   // operation codes (the spare code behaves as a search)
   localparam op_type OP_SEARCH = 2'd0;
   localparam op_type OP_INSERT = 2'd1;
   localparam op_type OP_REMOVE = 2'd2;
   localparam op_type OP_SPARE  = 2'd3;

   // slot states
   localparam slot_state_type SLOT_EMPTY = 2'd0;
   localparam slot_state_type SLOT_USED  = 2'd1;
   localparam slot_state_type SLOT_GONE  = 2'd2;

   // result status codes
   localparam status_type ST_OK     = 2'd0;
   localparam status_type ST_ABSENT = 2'd1;
   localparam status_type ST_FULL   = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // one table slot as held in memory
   typedef struct packed {
      slot_state_type      state;
      logic [KEY_W-1:0]    key;
      logic [COUNT_W-1:0]  count;
   } slot_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic load;
      logic mod_step;
      logic issue;
      logic finish;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic mod_last;
      logic issue_done;
      logic terminal;
      logic out_free;
   } dp_status_type;

endpackage

// ----- sv/chtq_req_if.sv -----
// request channel: operation and key
`timescale 1ns / 1ps

interface chtq_req_if import chtq_pkg::*; ();
   logic             valid;
   logic             ready;
   op_type           op;
   logic [KEY_W-1:0] key;

   modport source (output valid, output op, output key, input ready);
   modport sink   (input valid, input op, input key, output ready);
endinterface

// ----- sv/chtq_rsp_if.sv -----
// response channel: status and count
`timescale 1ns / 1ps

interface chtq_rsp_if import chtq_pkg::*; ();
   logic               valid;
   logic               ready;
   status_type         result_status;
   logic [COUNT_W-1:0] key_count;

   modport source (output valid, output result_status, output key_count, input ready);
   modport sink   (input valid, input result_status, input key_count, output ready);
endinterface

// ----- sv/chtq_datapath.sv -----
// slot memory, probe address generation, slot update and response register
`timescale 1ns / 1ps

module chtq_datapath import chtq_pkg::*; #(
   parameter int TABLE_SIZE = 16,
   parameter int MAX_PROBES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  ctrl_cmd_type       cmd,
   output dp_status_type      status,
   input  op_type             req_op,
   input  logic [KEY_W-1:0]   req_key,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output status_type         rsp_result_status,
   output logic [COUNT_W-1:0] rsp_key_count
);

   localparam int AW    = $clog2(TABLE_SIZE);
   localparam int SUM_W = AW + 1;
   localparam int CNT_W = $clog2(MAX_PROBES + 1);

   // item registers
   op_type               op_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [KEY_W-1:0]     key_sh_ff, key_sh_in;
   logic [MOD_CNT_W-1:0] mod_cnt_ff;

   // probe walk
   logic [AW-1:0]        pos_ff, pos_in;
   logic [AW-1:0]        step_ff, step_in;
   logic [CNT_W-1:0]     issue_cnt_ff;
   logic                 rd_valid_ff;
   logic                 rd_last_ff;
   logic [AW-1:0]        rd_pos_ff;
   slot_type             rd_data_ff;

   // clearing pass
   logic [AW-1:0]        clr_addr_ff;

   // response register
   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;

   slot_type             mem [TABLE_SIZE];

   // reduction scratch
   logic [AW-1:0]        rem;
   logic [SUM_W-1:0]     trial;
   logic [SUM_W-1:0]     pos_sum;
   logic [SUM_W-1:0]     step_sum;

   // decision on the slot just read
   logic                 is_empty;
   logic                 is_match;
   logic                 upd_wr;
   slot_type             upd_data;
   status_type           res_status;
   logic [COUNT_W-1:0]   res_count;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   slot_type             wr_data;

   // key mod table size, one key byte per cycle by shift and subtract
   always_comb begin
      rem   = pos_ff;
      trial = '0;
      for (int b = 0; b < MOD_BITS; b++) begin
         trial = {rem, key_sh_ff[KEY_W-1-b]};
         if (trial >= SUM_W'(TABLE_SIZE)) begin
            trial = trial - SUM_W'(TABLE_SIZE);
         end
         rem = trial[AW-1:0];
      end
      key_sh_in = key_sh_ff << MOD_BITS;
   end

   // next quadratic position: pos += 2i+1, step advances by two, both mod size
   always_comb begin
      pos_sum  = {1'b0, pos_ff} + {1'b0, step_ff};
      step_sum = {1'b0, step_ff} + SUM_W'(2);
      if (pos_sum >= SUM_W'(TABLE_SIZE)) begin
         pos_sum = pos_sum - SUM_W'(TABLE_SIZE);
      end
      if (step_sum >= SUM_W'(TABLE_SIZE)) begin
         step_sum = step_sum - SUM_W'(TABLE_SIZE);
      end
      pos_in  = pos_sum[AW-1:0];
      step_in = step_sum[AW-1:0];
   end

   // classify the slot and work out its update and the result
   always_comb begin
      is_empty   = (rd_data_ff.state == SLOT_EMPTY);
      is_match   = (rd_data_ff.state == SLOT_USED) && (rd_data_ff.key == key_ff);
      upd_wr     = 1'b0;
      upd_data   = rd_data_ff;
      res_status = (op_ff == OP_INSERT) ? ST_FULL : ST_ABSENT;
      res_count  = '0;
      if (is_empty) begin
         if (op_ff == OP_INSERT) begin
            upd_wr         = 1'b1;
            upd_data.state = SLOT_USED;
            upd_data.key   = key_ff;
            upd_data.count = COUNT_W'(1);
            res_status     = ST_OK;
            res_count      = COUNT_W'(1);
         end
      end else if (is_match) begin
         res_status = ST_OK;
         res_count  = rd_data_ff.count;
         case (op_ff)
            OP_INSERT: begin
               upd_wr = 1'b1;
               if (rd_data_ff.count != COUNT_MAX) begin
                  upd_data.count = rd_data_ff.count + COUNT_W'(1);
               end
               res_count = upd_data.count;
            end
            OP_REMOVE: begin
               upd_wr = 1'b1;
               if (rd_data_ff.count > COUNT_W'(1)) begin
                  upd_data.count = rd_data_ff.count - COUNT_W'(1);
                  res_count      = upd_data.count;
               end else begin
                  upd_data.state = SLOT_GONE;
                  res_count      = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // memory write port: clearing pass or slot update
   always_comb begin
      wr_en   = cmd.clear_step || (cmd.finish && upd_wr);
      wr_addr = cmd.clear_step ? clr_addr_ff : rd_pos_ff;
      wr_data = upd_data;
      if (cmd.clear_step) begin
         wr_data       = '0;
         wr_data.state = SLOT_EMPTY;
      end
   end

   // slot memory, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.issue) begin
         rd_data_ff <= mem[pos_ff];
      end
   end

   // item and probe payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_op;
         key_ff    <= req_key;
         key_sh_ff <= req_key;
         pos_ff    <= '0;
         step_ff   <= AW'(1);
      end else if (cmd.mod_step) begin
         key_sh_ff <= key_sh_in;
         pos_ff    <= rem;
      end else if (cmd.issue) begin
         pos_ff    <= pos_in;
         step_ff   <= step_in;
      end
      if (cmd.issue) begin
         rd_pos_ff  <= pos_ff;
         rd_last_ff <= (issue_cnt_ff == CNT_W'(MAX_PROBES - 1));
      end
      if (cmd.finish) begin
         rsp_status_ff <= res_status;
         rsp_count_ff  <= res_count;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         mod_cnt_ff   <= '0;
         issue_cnt_ff <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_step) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
         end
         if (cmd.load) begin
            mod_cnt_ff   <= '0;
            issue_cnt_ff <= '0;
            rd_valid_ff  <= 1'b0;
         end else begin
            if (cmd.mod_step) begin
               mod_cnt_ff <= mod_cnt_ff + MOD_CNT_W'(1);
            end
            if (cmd.issue) begin
               issue_cnt_ff <= issue_cnt_ff + CNT_W'(1);
               rd_valid_ff  <= 1'b1;
            end else if (cmd.finish) begin
               rd_valid_ff  <= 1'b0;
            end
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // status back to the controller
   always_comb begin
      status.clear_last = (clr_addr_ff == AW'(TABLE_SIZE - 1));
      status.mod_last   = (mod_cnt_ff == MOD_CNT_W'(MOD_STEPS - 1));
      status.issue_done = (issue_cnt_ff == CNT_W'(MAX_PROBES));
      status.terminal   = rd_valid_ff && (is_empty || is_match || rd_last_ff);
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_status = rsp_status_ff;
   assign rsp_key_count     = rsp_count_ff;

endmodule

// ----- sv/chtq_ctrl.sv -----
// controller: clearing pass, key reduction and probe sequencing
`timescale 1ns / 1ps

module chtq_ctrl import chtq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_MOD,
      S_PROBE
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   // commands and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd.load = req_valid && ready_ff;
            if (cmd.load) begin
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (status.mod_last) begin
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            // whole walk holds while the response register is occupied and not being taken
            cmd.finish = status.out_free && status.terminal;
            cmd.issue  = status.out_free && !status.terminal && !status.issue_done;
            if (cmd.finish) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // state and registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IDLE);
      end
   end

   assign req_ready = ready_ff;

endmodule

// ----- sv/counting_hash_table_quadratic_probe.sv -----
// top level of the counting hash table with quadratic probing
`timescale 1ns / 1ps

// Counting multiset of TABLE_SIZE slots probed at (key + i*i) mod TABLE_SIZE,
// up to MAX_PROBES probes. Each request (search, insert, remove) gives one
// response with a status and the key's count afterwards. After reset the block
// clears the slot memory one slot at a time and takes no request meanwhile.
// Each waiting request then passes through the accept in idle, the steps that
// reduce the key modulo the table size a byte at a time, one probe per cycle
// while the response register is free for each of the 1 to MAX_PROBES slots
// probed, through the single registered read port of the slot memory, and a
// final step that checks the last slot read, writes it back and loads the
// response. A new request is taken while the last response still waits;
// probing stalls only while that response is not yet taken.

module counting_hash_table_quadratic_probe import chtq_pkg::*; #(
   parameter int TABLE_SIZE = 16,
   parameter int MAX_PROBES = 16
) (
   input  logic       clock,
   input  logic       reset,
   chtq_req_if.sink   req_bus,
   chtq_rsp_if.source rsp_bus
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencing
   chtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // table and response
   chtq_datapath #(
      .TABLE_SIZE (TABLE_SIZE),
      .MAX_PROBES (MAX_PROBES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_op            (req_bus.op),
      .req_key           (req_bus.key),
      .rsp_ready         (rsp_bus.ready),
      .rsp_valid         (rsp_bus.valid),
      .rsp_result_status (rsp_bus.result_status),
      .rsp_key_count     (rsp_bus.key_count)
   );

endmodule

// ----- sv/chtq_checker.sv -----
// port checker for the counting hash table, bound to the top level
`timescale 1ns / 1ps

module chtq_checker import chtq_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input status_type         rsp_result_status,
   input logic [COUNT_W-1:0] rsp_key_count
);

   logic [1:0] pending_ff;

   // requests taken but not yet answered
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
      end
   end

   // every response beat answers a request
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response beat without a request");

   // at most one item in work and one response waiting
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("too many requests outstanding");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_status)
         && $stable(rsp_key_count))
      else $error("stalled response changed");

   // absent or full gives a zero count
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_status != ST_OK |-> rsp_key_count == '0)
      else $error("non-zero count on a failed operation");

   // only defined status codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result_status == ST_OK || rsp_result_status == ST_ABSENT
         || rsp_result_status == ST_FULL)
      else $error("undefined status code");

endmodule

bind counting_hash_table_quadratic_probe chtq_checker u_chtq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_result_status (rsp_bus.result_status),
   .rsp_key_count     (rsp_bus.key_count)
);

// ----- test/tb_counting_hash_table_quadratic_probe.sv -----
// testbench of the counting hash table: directed, count climb, random and back-pressure traffic
`timescale 1ns / 1ps

module tb_counting_hash_table_quadratic_probe;
   import chtq_pkg::*;

   localparam int N_SLOTS       = 16;
   localparam int PROBE_LIMIT   = 16;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 400_000;
   localparam int REPORT_CAP    = 200;
   localparam int CLIMB_REPEAT  = 60;

   // one response as the table should give it
   typedef struct packed {
      status_type         status;
      logic [COUNT_W-1:0] count;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   chtq_req_if req_bus ();
   chtq_rsp_if rsp_bus ();

   counting_hash_table_quadratic_probe #(
      .TABLE_SIZE (N_SLOTS),
      .MAX_PROBES (PROBE_LIMIT)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // shadow copy of the slot memory
   slot_state_type     shadow_state [N_SLOTS];
   logic [KEY_W-1:0]   shadow_key   [N_SLOTS];
   logic [COUNT_W-1:0] shadow_count [N_SLOTS];

   outcome_type pending_outcomes[$];

   int send_gap_max   = 0;
   int recv_gap_max   = 0;
   int recv_hold_left = 0;
   int long_hold_len  = 0;
   int long_hold_seq  = 0;
   int long_hold_ack  = 0;
   int beats_seen     = 0;
   int beats_used     = 0;

   int mismatches  = 0;
   int cycle_count = 0;
   int ops_issued [4];
   int status_seen [4];
   int peak_count  = 0;

   // clock
   always #2 clock = ~clock;

   // run guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d responses outstanding", $realtime,
                  cycle_count, pending_outcomes.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // apply one operation to the shadow table and return what the block should answer
   function automatic outcome_type table_apply(input op_type op, input logic [KEY_W-1:0] key);
      outcome_type        res;
      int unsigned        slot;
      logic [COUNT_W-1:0] c;
      res.status = (op == OP_INSERT) ? ST_FULL : ST_ABSENT;
      res.count  = '0;
      for (int p = 0; p < PROBE_LIMIT; p++) begin
         slot = int'((64'(key) + 64'(p) * 64'(p)) % 64'(N_SLOTS));
         // empty slot ends the walk: insert claims it, the others miss
         if (shadow_state[slot] == SLOT_EMPTY) begin
            if (op == OP_INSERT) begin
               shadow_state[slot] = SLOT_USED;
               shadow_key[slot]   = key;
               shadow_count[slot] = COUNT_W'(1);
               res.status         = ST_OK;
               res.count          = COUNT_W'(1);
            end else begin
               res.status = ST_ABSENT;
               res.count  = '0;
            end
            break;
         end
         // hit on a live slot
         if (shadow_state[slot] == SLOT_USED && shadow_key[slot] == key) begin
            c = shadow_count[slot];
            if (op == OP_INSERT) begin
               if (c != COUNT_MAX) c = c + 1'b1;
               shadow_count[slot] = c;
            end else if (op == OP_REMOVE) begin
               if (c > COUNT_W'(1)) begin
                  c = c - 1'b1;
                  shadow_count[slot] = c;
               end else begin
                  shadow_state[slot] = SLOT_GONE;
                  c = '0;
               end
            end
            res.status = ST_OK;
            res.count  = c;
            break;
         end
         // deleted slot or another key: carry on probing
      end
      return res;
   endfunction

   // drive one request beat, with a random gap in front of it
   task automatic send_request(input op_type op, input logic [KEY_W-1:0] key);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      @(negedge clock);
      repeat (gap) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op    <= op;
      req_bus.key   <= key;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_outcomes.push_back(table_apply(op, key));
      ops_issued[op]++;
   endtask

   // response ready: random stalls per beat, or one long hold when asked
   always @(negedge clock) begin
      if (long_hold_seq != long_hold_ack) begin
         recv_hold_left = long_hold_len;
         long_hold_ack  = long_hold_seq;
         beats_used     = beats_seen;
      end else if (beats_used != beats_seen) begin
         recv_hold_left = $urandom_range(0, recv_gap_max);
         beats_used     = beats_seen;
      end
      if (recv_hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         recv_hold_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // response checker: each beat against the oldest prediction
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         beats_seen++;
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
               $display("%0t: response with nothing expected, got status %0d count %0d",
                        $realtime, rsp_bus.result_status, rsp_bus.key_count);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_bus.result_status !== want.status) begin
               mismatches++;
               if (mismatches <= REPORT_CAP)
                  $display("%0t: result_status expected %0d actual %0d", $realtime,
                           want.status, rsp_bus.result_status);
            end
            if (rsp_bus.key_count !== want.count) begin
               mismatches++;
               if (mismatches <= REPORT_CAP)
                  $display("%0t: key_count expected %0d actual %0d", $realtime,
                           want.count, rsp_bus.key_count);
            end
            status_seen[want.status]++;
            if (int'(want.count) > peak_count) peak_count = int'(want.count);
         end
      end
   end

   // hand-picked cases: misses, hits, collisions, full path, deleted slots, key extremes
   task automatic test_directed_cases();
      send_gap_max = 3;
      recv_gap_max = 3;
      send_request(OP_SEARCH, 32'h0000_0000);   // miss on empty table
      send_request(OP_REMOVE, 32'h0000_0000);   // remove of absent key
      send_request(OP_INSERT, 32'h0000_0010);
      send_request(OP_INSERT, 32'h0000_0010);   // count goes to two
      send_request(OP_SPARE,  32'h0000_0010);   // spare code acts as search
      send_request(OP_INSERT, 32'h0000_0020);   // collides, next probe
      send_request(OP_INSERT, 32'h0000_0030);
      send_request(OP_INSERT, 32'h0000_0040);   // whole probe path now taken
      send_request(OP_INSERT, 32'h0000_0050);   // probe path full, status full
      send_request(OP_SEARCH, 32'h0000_0050);   // probe limit on search
      send_request(OP_REMOVE, 32'h0000_0050);   // probe limit on remove
      send_request(OP_REMOVE, 32'h0000_0010);
      send_request(OP_REMOVE, 32'h0000_0010);   // last copy, slot deleted
      send_request(OP_SEARCH, 32'h0000_0010);
      send_request(OP_SEARCH, 32'h0000_0040);   // walks past the deleted slot
      send_request(OP_INSERT, 32'h0000_0010);   // deleted slot not reused
      send_request(OP_INSERT, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 32'hFFFF_FFFF);
      send_request(OP_SPARE,  32'hFFFF_FFFF);
      send_request(OP_REMOVE, 32'hFFFF_FFFF);
      send_request(OP_REMOVE, 32'hFFFF_FFFF);
      send_request(OP_SEARCH, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 32'h0000_0000);
      send_request(OP_SEARCH, 32'h8000_0001);
   endtask

   // push one key's count well up back to back, then back down a little
   task automatic test_count_climb();
      logic [KEY_W-1:0] key;
      int               home;
      home = -1;
      for (int s = 0; s < N_SLOTS; s++)
         if (home < 0 && shadow_state[s] == SLOT_EMPTY) home = s;
      if (home < 0) return;
      key          = $urandom;
      key[3:0]     = 4'(home);
      send_gap_max = 0;
      recv_gap_max = 0;
      repeat (CLIMB_REPEAT) send_request(OP_INSERT, key);
      send_request(OP_SEARCH, key);
      send_request(OP_REMOVE, key);
      send_request(OP_INSERT, key);
      send_request(OP_REMOVE, key);
   endtask

   // mostly traffic on a small key pool so hits and collisions stay common
   task automatic test_random_traffic(input int n_items);
      logic [KEY_W-1:0] pool [12];
      int               pool_len;
      int               pick;
      op_type           op;
      logic [KEY_W-1:0] key;
      pool_len = 1;
      for (int n = 0; n < n_items; n++) begin
         // fresh pool and idling pattern per segment
         if (n % 100 == 0) begin
            pool_len = $urandom_range(4, 12);
            for (int j = 0; j < pool_len; j++) pool[j] = $urandom;
            send_gap_max = ((n / 100) % 4 == 3) ? 0 : 9;
            recv_gap_max = ((n / 100) % 3 == 2) ? 0 : 9;
         end
         pick = $urandom_range(0, 99);
         if (pick < 45)      op = OP_INSERT;
         else if (pick < 75) op = OP_SEARCH;
         else if (pick < 93) op = OP_REMOVE;
         else                op = OP_SPARE;
         key = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, pool_len - 1)];
         send_request(op, key);
      end
   endtask

   // receiver holds off for a long stretch while requests keep coming
   task automatic test_output_backpressure();
      send_gap_max  = 0;
      recv_gap_max  = 2;
      long_hold_len = 400;
      long_hold_seq++;
      for (int n = 0; n < 40; n++)
         send_request(2'($urandom_range(0, 3)), (n % 2 == 0) ? $urandom : 32'(n % 8));
   endtask

   // stop sending and let every predicted response come back
   task automatic drain_responses();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.op    = OP_SEARCH;
      req_bus.key   = '0;
      for (int s = 0; s < N_SLOTS; s++) begin
         shadow_state[s] = SLOT_EMPTY;
         shadow_key[s]   = '0;
         shadow_count[s] = '0;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_count_climb();
      test_random_traffic(1200);
      test_output_backpressure();
      test_random_traffic(100);
      drain_responses();

      $display("covered %0d searches, %0d inserts, %0d removes, %0d spare-code ops",
               ops_issued[OP_SEARCH], ops_issued[OP_INSERT], ops_issued[OP_REMOVE],
               ops_issued[OP_SPARE]);
      $display("answers: %0d found or done, %0d absent, %0d full; highest count %0d",
               status_seen[ST_OK], status_seen[ST_ABSENT], status_seen[ST_FULL], peak_count);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
